// ===== rtl/core/afu_pkg.sv =====
package afu_pkg;

    // Fixed field widths and defaults.
    localparam int SAMPLE_W      = 16;
    localparam int FSEL_W        = 3;
    localparam int FRAC_BITS_DEF = 12;

    // The exponential datapath works in unsigned Q1.30.
    localparam int EXP_FRAC = 30;
    localparam int EXP_W    = EXP_FRAC + 1;

    // Numerator and denominator width of the divider.
    localparam int DIV_W = 64;

    // Exponent argument is the magnitude or twice the magnitude.
    localparam int ARG_W = SAMPLE_W + 1;

    typedef enum logic [FSEL_W-1:0] {
        FN_IDENTITY = 3'd0,
        FN_SIGMOID  = 3'd1,
        FN_TANH     = 3'd2,
        FN_RELU     = 3'd3,
        FN_SOFTSIGN = 3'd4,
        FN_SHIFTED  = 3'd5
    } func_sel_t;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic negate;
        logic use_div;
    } afu_side_t;

    // Rounded exp(-k * 2^shift / 2^frac_bits) in Q1.30, for table building.
    function automatic logic [EXP_W-1:0] exp_q(input int unsigned k, input int shift,
                                               input int frac_bits);
        real arg;
        real v;
        arg = real'(k) * (2.0 ** (shift - frac_bits));
        v   = $exp(-arg) * (2.0 ** EXP_FRAC) + 0.5;
        return EXP_W'($rtoi(v));
    endfunction

endpackage

// ===== rtl/core/afu_exp.sv =====
module afu_exp
    import afu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [ARG_W-1:0] arg,
    output logic [EXP_W-1:0] e
);

    localparam int LO_W  = 6;
    localparam int MID_W = 6;
    localparam int HI_W  = ARG_W - LO_W - MID_W;

    logic [EXP_W-1:0] tab_lo  [2**LO_W];
    logic [EXP_W-1:0] tab_mid [2**MID_W];
    logic [EXP_W-1:0] tab_hi  [2**HI_W];

    logic [EXP_W-1:0] t_lo_reg;
    logic [EXP_W-1:0] t_mid_reg;
    logic [EXP_W-1:0] t_hi_reg;
    logic [EXP_W-1:0] t_hi_d_reg;
    logic [EXP_W-1:0] p_reg;
    logic [EXP_W-1:0] e_reg;

    logic [2*EXP_W-1:0] prod_a;
    logic [2*EXP_W-1:0] prod_b;

    // Constant tables of exp over the three argument chunks.
    for (genvar i = 0; i < 2**LO_W; i++) begin : g_lo
        assign tab_lo[i] = exp_q(i, 0, FRAC_BITS);
    end
    for (genvar i = 0; i < 2**MID_W; i++) begin : g_mid
        assign tab_mid[i] = exp_q(i, LO_W, FRAC_BITS);
    end
    for (genvar i = 0; i < 2**HI_W; i++) begin : g_hi
        assign tab_hi[i] = exp_q(i, LO_W + MID_W, FRAC_BITS);
    end

    assign prod_a = t_lo_reg * t_mid_reg;
    assign prod_b = p_reg * t_hi_d_reg;

    // Lookup, first product, second product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_lo_reg   <= tab_lo[arg[LO_W-1:0]];
            t_mid_reg  <= tab_mid[arg[LO_W +: MID_W]];
            t_hi_reg   <= tab_hi[arg[ARG_W-1 -: HI_W]];
            p_reg      <= prod_a[EXP_FRAC +: EXP_W];
            t_hi_d_reg <= t_hi_reg;
            e_reg      <= prod_b[EXP_FRAC +: EXP_W];
        end
    end

    assign e = e_reg;

endmodule

// ===== rtl/core/afu_div.sv =====
module afu_div
    import afu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BYP_W     = 17
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [DIV_W-1:0]          num,
    input  logic [DIV_W-1:0]          den,
    input  afu_side_t                 in_side,
    input  logic signed [BYP_W-1:0]   in_byp,
    output logic                      out_valid,
    output logic [FRAC_BITS+1:0]      quo,
    output afu_side_t                 out_side,
    output logic signed [BYP_W-1:0]   out_byp
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 2;

    logic                    v_reg    [STEPS+1];
    logic [DIV_W-1:0]        rem_reg  [STEPS+1];
    logic [DIV_W-1:0]        den_reg  [STEPS+1];
    logic [QW-1:0]           q_reg    [STEPS+1];
    afu_side_t               side_reg [STEPS+1];
    logic signed [BYP_W-1:0] byp_reg  [STEPS+1];

    // Entry register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
            byp_reg[0]  <= in_byp;
        end
    end

    // One restoring quotient bit per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DIV_W:0]   sh;
        logic [DIV_W:0]   diff;
        logic             ge;
        logic [DIV_W-1:0] rem_next;
        logic [QW-1:0]    q_next;

        always_comb
        begin
            sh       = {rem_reg[k], 1'b0};
            diff     = sh - {1'b0, den_reg[k]};
            ge       = (sh >= {1'b0, den_reg[k]});
            rem_next = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
            q_next   = {q_reg[k][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_reg[k];
                q_reg[k+1]    <= q_next;
                side_reg[k+1] <= side_reg[k];
                byp_reg[k+1]  <= byp_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign quo       = q_reg[STEPS];
    assign out_side  = side_reg[STEPS];
    assign out_byp   = byp_reg[STEPS];

endmodule

// ===== rtl/core/activation_function_unit_top.sv =====
// Activation function unit: one signed Q4.12 sample (FRAC_BITS fraction bits) and an
// action bit go in, and the value or derivative of the selected function comes out,
// rounded to nearest and saturated to 16 bits. A new sample is taken every cycle
// in which the output is not stalled. Five stages of exponential lookup, products
// and operand setup feed the divider, which resolves one quotient bit per stage;
// the output register follows it. The whole pipeline holds while a finished
// result waits at the output. function_select is written through the cfg port
// and applies to samples taken after the write.
module activation_function_unit_top
    import afu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [FSEL_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] value
);

    localparam int RW   = (FRAC_BITS + 3 > SAMPLE_W + 1) ? FRAC_BITS + 3 : SAMPLE_W + 1;
    localparam int DW   = ((FRAC_BITS + 1 > SAMPLE_W) ? FRAC_BITS + 1 : SAMPLE_W) + 1;
    localparam int QW   = FRAC_BITS + 2;
    localparam logic signed [RW-1:0] ONE_R  = RW'(1) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);
    localparam logic [DIV_W-1:0] ONE_F  = DIV_W'(1) << FRAC_BITS;
    localparam logic [DIV_W-1:0] ONE_F2 = DIV_W'(1) << (2 * FRAC_BITS);
    localparam logic [DIV_W-1:0] ONE_E  = DIV_W'(1) << EXP_FRAC;

    func_sel_t fsel_reg;
    logic      en;

    // Input side.
    logic                 in_neg;
    logic [SAMPLE_W-1:0]  in_a;
    logic signed [RW-1:0] in_sx;
    logic signed [RW-1:0] in_byp;

    // Stage registers ahead of the divider.
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic                 s1_act_reg, s2_act_reg, s3_act_reg, s4_act_reg, s5_act_reg;
    func_sel_t            s1_fsel_reg, s2_fsel_reg, s3_fsel_reg, s4_fsel_reg, s5_fsel_reg;
    logic                 s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg;
    logic [SAMPLE_W-1:0]  s1_a_reg, s2_a_reg, s3_a_reg, s4_a_reg, s5_a_reg;
    logic signed [RW-1:0] s1_byp_reg, s2_byp_reg, s3_byp_reg, s4_byp_reg, s5_byp_reg;
    logic [DW-1:0]        s2_d_reg, s3_d_reg, s4_d_reg, s5_d_reg;
    logic [2*DW-1:0]      s3_dsq_reg, s4_dsq_reg, s5_dsq_reg;
    logic [EXP_W-1:0]     s5_e_reg;
    logic [DIV_W-1:0]     s5_opsq_reg;

    logic [ARG_W-1:0]     exp_arg;
    logic [EXP_W-1:0]     exp_e;
    logic [DIV_W-1:0]     ope;

    // Divider operands.
    logic [DIV_W-1:0]     div_num;
    logic [DIV_W-1:0]     div_den;
    afu_side_t            div_side;

    logic                 dv_valid;
    logic [QW-1:0]        dv_quo;
    afu_side_t            dv_side;
    logic signed [RW-1:0] dv_byp;

    // Output stage.
    logic [QW:0]          rnd_sum;
    logic signed [RW-1:0] mag;
    logic signed [RW-1:0] res;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                 out_valid_reg;
    logic signed [SAMPLE_W-1:0] value_reg;

    // The whole pipeline moves unless a result waits at the output.
    assign en        = out_ready || !out_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Function select register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsel_reg <= FN_IDENTITY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fsel_reg <= func_sel_t'(cfg_data);
        end
    end

    // Magnitude, and results of identity and ReLU that need no arithmetic.
    always_comb
    begin
        in_neg = sample[SAMPLE_W-1];
        in_a   = in_neg ? SAMPLE_W'(-sample) : sample;
        in_sx  = RW'(sample);
        case (fsel_reg)
            FN_IDENTITY: in_byp = action ? ONE_R : in_sx;
            FN_RELU:     in_byp = (!in_neg && (sample != '0)) ? (action ? ONE_R : in_sx) : '0;
            default:     in_byp = '0;
        endcase
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Front stage payload: denominator terms, squares and carried fields.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_act_reg  <= action;
            s1_fsel_reg <= fsel_reg;
            s1_neg_reg  <= in_neg;
            s1_a_reg    <= in_a;
            s1_byp_reg  <= in_byp;

            s2_act_reg  <= s1_act_reg;
            s2_fsel_reg <= s1_fsel_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_a_reg    <= s1_a_reg;
            s2_byp_reg  <= s1_byp_reg;
            s2_d_reg    <= DW'(ONE_F) + DW'(s1_a_reg);

            s3_act_reg  <= s2_act_reg;
            s3_fsel_reg <= s2_fsel_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_a_reg    <= s2_a_reg;
            s3_byp_reg  <= s2_byp_reg;
            s3_d_reg    <= s2_d_reg;
            s3_dsq_reg  <= s2_d_reg * s2_d_reg;

            s4_act_reg  <= s3_act_reg;
            s4_fsel_reg <= s3_fsel_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_a_reg    <= s3_a_reg;
            s4_byp_reg  <= s3_byp_reg;
            s4_d_reg    <= s3_d_reg;
            s4_dsq_reg  <= s3_dsq_reg;

            s5_act_reg  <= s4_act_reg;
            s5_fsel_reg <= s4_fsel_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_a_reg    <= s4_a_reg;
            s5_byp_reg  <= s4_byp_reg;
            s5_d_reg    <= s4_d_reg;
            s5_dsq_reg  <= s4_dsq_reg;
            s5_e_reg    <= exp_e;
            s5_opsq_reg <= ope * ope;
        end
    end

    // Tanh uses exp of twice the magnitude.
    assign exp_arg = (s1_fsel_reg == FN_TANH) ? {s1_a_reg, 1'b0} : {1'b0, s1_a_reg};
    assign ope     = ONE_E + DIV_W'(exp_e);

    afu_exp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_exp (
        .clk (clk),
        .en  (en),
        .arg (exp_arg),
        .e   (exp_e)
    );

    // Numerator and denominator of each function; every quotient lies in [0, 1].
    always_comb
    begin
        div_num          = '0;
        div_den          = DIV_W'(1);
        div_side.use_div = 1'b1;
        div_side.negate  = 1'b0;
        case (s5_fsel_reg)
            FN_SIGMOID:
            begin
                if (s5_act_reg)
                begin
                    div_num = DIV_W'(s5_e_reg) << EXP_FRAC;
                    div_den = s5_opsq_reg;
                end
                else
                begin
                    div_num = s5_neg_reg ? DIV_W'(s5_e_reg) : ONE_E;
                    div_den = ONE_E + DIV_W'(s5_e_reg);
                end
            end
            FN_TANH:
            begin
                if (s5_act_reg)
                begin
                    div_num = DIV_W'(s5_e_reg) << (EXP_FRAC + 2);
                    div_den = s5_opsq_reg;
                end
                else
                begin
                    div_num         = ONE_E - DIV_W'(s5_e_reg);
                    div_den         = ONE_E + DIV_W'(s5_e_reg);
                    div_side.negate = s5_neg_reg;
                end
            end
            FN_SOFTSIGN:
            begin
                if (s5_act_reg)
                begin
                    div_num = ONE_F2;
                    div_den = DIV_W'(s5_dsq_reg);
                end
                else
                begin
                    div_num         = DIV_W'(s5_a_reg);
                    div_den         = DIV_W'(s5_d_reg);
                    div_side.negate = s5_neg_reg;
                end
            end
            FN_SHIFTED:
            begin
                if (s5_act_reg)
                begin
                    div_num = ONE_F2;
                    div_den = DIV_W'(s5_dsq_reg) << 1;
                end
                else
                begin
                    div_num = s5_neg_reg ? ONE_F : ONE_F + (DIV_W'(s5_a_reg) << 1);
                    div_den = DIV_W'(s5_d_reg) << 1;
                end
            end
            default:
            begin
                div_side.use_div = 1'b0;
            end
        endcase
    end

    afu_div #(
        .FRAC_BITS (FRAC_BITS),
        .BYP_W     (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .num       (div_num),
        .den       (div_den),
        .in_side   (div_side),
        .in_byp    (s5_byp_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_side  (dv_side),
        .out_byp   (dv_byp)
    );

    // Round half up from one extra quotient bit, apply sign, saturate.
    always_comb
    begin
        rnd_sum = {1'b0, dv_quo} + (QW+1)'(1);
        mag     = RW'(rnd_sum[QW:1]);
        if (dv_side.use_div)
        begin
            res = dv_side.negate ? -mag : mag;
        end
        else
        begin
            res = dv_byp;
        end
        if (res > SAT_HI)
        begin
            value_next = SAMPLE_W'(SAT_HI);
        end
        else if (res < SAT_LO)
        begin
            value_next = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            value_next = res[SAMPLE_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

// ===== rtl/core/afu_checker.sv =====
module afu_checker
    import afu_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_ready,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] value
);

    // A waiting result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result changed before its transfer");

    // With no result waiting, the input side is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output is empty");

    // A stalled output holds the whole pipeline, input included.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline is stalled");

    // The configuration port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind activation_function_unit_top afu_checker u_afu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
);

// ===== test/activation_function_unit_top_tb.sv =====
`timescale 1ns / 1ps

module activation_function_unit_top_tb;
    import afu_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int Q48           = 48;
    localparam int SERIES_TERMS  = 24;
    localparam int PIPE_LATENCY  = FRAC + 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [63:0] Q48_ONE = 64'd1 << Q48;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [FSEL_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] value;

    // Expected results, oldest first, and the predictor's copy of the select register.
    logic signed [SAMPLE_W-1:0] expected_values[$];
    logic [FSEL_W-1:0]          select_copy;
    int                         mismatch_count;
    int                         cycle_count;
    bit                         idling_on;
    int                         hold_cycles;

    activation_function_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Exact floor(a * b / 2^48) for operands below 2^50.
    function automatic logic [63:0] mul_q48(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a1, a0, b1, b0, mid, low;
        a1  = a >> 25;
        a0  = a & ((64'd1 << 25) - 1);
        b1  = b >> 25;
        b0  = b & ((64'd1 << 25) - 1);
        mid = a1 * b0 + a0 * b1;
        low = a0 * b0;
        return ((a1 * b1) << 2) + ((mid + (low >> 25)) >> 23);
    endfunction

    // floor(n * 2^48 / d) by restoring long division.
    function automatic logic [63:0] div_q48(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        for (int i = 0; i < Q48; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-f) for f in [0, 1], Q48, by Taylor series.
    function automatic logic [63:0] exp_frac(input logic [63:0] f);
        logic [63:0] sum, term;
        sum  = Q48_ONE;
        term = Q48_ONE;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = mul_q48(term, f) / k;
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // exp(-y) for any non-negative Q48 argument.
    function automatic logic [63:0] exp_neg_q48(input logic [63:0] y);
        logic [63:0] whole, e, e1;
        whole = y >> Q48;
        e     = exp_frac(y & (Q48_ONE - 1));
        if (whole > 0)
        begin
            e1 = exp_frac(Q48_ONE);
            while (whole > 0 && e != 0)
            begin
                e     = mul_q48(e, e1);
                whole = whole - 1;
            end
        end
        return e;
    endfunction

    function automatic longint round_q48(input logic [63:0] m);
        return longint'((m + (64'd1 << (Q48 - FRAC - 1))) >> (Q48 - FRAC));
    endfunction

    // Expected output for one sample under the given function select.
    function automatic logic signed [SAMPLE_W-1:0] activation_result(
        input logic [FSEL_W-1:0] fsel, input logic deriv, input logic signed [SAMPLE_W-1:0] smp);
        longint      s, r;
        logic [63:0] mag, one_f, y, d, e, p, q, d2, s3, num;
        bit          neg;
        s     = longint'(smp);
        neg   = s < 0;
        mag   = neg ? -s : s;
        one_f = 64'd1 << FRAC;
        y     = mag << (Q48 - FRAC);
        d     = one_f + mag;
        s3    = one_f * one_f * one_f;
        d2    = d * d;
        r     = 0;
        case (fsel)
            FN_IDENTITY:
                r = deriv ? longint'(one_f) : s;
            FN_SIGMOID:
            begin
                e = exp_neg_q48(y);
                p = div_q48(e, Q48_ONE + e);
                q = div_q48(Q48_ONE, Q48_ONE + e);
                if (deriv)
                    r = round_q48(mul_q48(p, q));
                else
                    r = round_q48(neg ? p : q);
            end
            FN_TANH:
            begin
                e = exp_neg_q48(y << 1);
                p = div_q48(e, Q48_ONE + e);
                q = div_q48(Q48_ONE, Q48_ONE + e);
                if (deriv)
                    r = round_q48(mul_q48(p, q) << 2);
                else
                begin
                    r = round_q48(div_q48(Q48_ONE - e, Q48_ONE + e));
                    if (neg)
                        r = -r;
                end
            end
            FN_RELU:
                r = (s > 0) ? (deriv ? longint'(one_f) : s) : 0;
            FN_SOFTSIGN:
            begin
                if (deriv)
                    r = longint'((2 * s3 + d2) / (2 * d2));
                else
                begin
                    r = longint'((2 * mag * one_f + d) / (2 * d));
                    if (neg)
                        r = -r;
                end
            end
            FN_SHIFTED:
            begin
                if (deriv)
                    r = longint'((s3 + d2) / (2 * d2));
                else
                begin
                    num = one_f * (neg ? one_f : one_f + 2 * mag);
                    r   = longint'((num + d) / (2 * d));
                end
            end
            default:
                r = 0;
        endcase
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[SAMPLE_W-1:0];
    endfunction

    // Result checker: every output transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, value);
                mismatch_count++;
            end
            else if (value !== expected_values[0])
            begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, expected_values[0], value);
                mismatch_count++;
                void'(expected_values.pop_front());
            end
            else
                void'(expected_values.pop_front());
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("activation_function_unit_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls per result while idling is on, plus an occasional long hold-off.
    initial
    begin
        int stall;
        bit taken;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = idling_on ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = out_valid;
                @(posedge clk);
            end
            while (!taken);
        end
    end

    // Sends one sample; the expectation is queued just before the accepting edge.
    task automatic send_sample(input logic act, input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        bit accepted;
        gap = idling_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= smp;
        do
        begin
            @(negedge clk);
            accepted = in_ready;
            if (accepted)
                expected_values.push_back(activation_result(select_copy, act, smp));
            @(posedge clk);
        end
        while (!accepted);
    endtask

    // Stops sending and waits for every outstanding result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    // Writes the function select once the pipeline is empty.
    task automatic write_select(input logic [FSEL_W-1:0] fsel);
        bit accepted;
        drain_results();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= fsel;
        do
        begin
            @(negedge clk);
            accepted = cfg_ready;
            @(posedge clk);
        end
        while (!accepted);
        cfg_valid   <= 1'b0;
        select_copy = fsel;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_W'($urandom_range(0, 65535));
            1: return SAMPLE_W'($urandom_range(0, 16384) - 8192);
            2: return SAMPLE_W'($urandom_range(0, 512) - 256);
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Default select after reset, then the field extremes under every function.
    task automatic test_directed();
        logic [FSEL_W-1:0] fsel;
        send_sample(1'b0, 16'sh7FFF);
        send_sample(1'b1, -16'sd1);
        for (int f = 0; f < 8; f++)
        begin
            fsel = FSEL_W'(f);
            write_select(fsel);
            send_sample(1'b0, -16'sh8000);
            send_sample(1'b1, 16'sh7FFF);
            send_sample(1'b0, 16'sd0);
            send_sample(1'b1, 16'sd0);
        end
    endtask

    // Random samples per function, idling on both sides; then sigmoid, idling toggled.
    task automatic test_random(input int per_select);
        logic [FSEL_W-1:0] fsel;
        idling_on = 1'b1;
        for (int f = 0; f < 8; f++)
        begin
            fsel = (f < 6) ? FSEL_W'(f) : FSEL_W'($urandom_range(0, 7));
            write_select(fsel);
            for (int i = 0; i < per_select; i++)
                send_sample(1'($urandom_range(0, 1)), random_sample());
        end
        write_select(FN_SIGMOID);
        for (int i = 0; i < per_select; i++)
        begin
            idling_on = (i % 40) < 20;
            send_sample(1'($urandom_range(0, 1)), random_sample());
        end
        idling_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps going, so the pipeline fills.
    task automatic test_backpressure();
        write_select(FN_TANH);
        idling_on   = 1'b0;
        hold_cycles = 150;
        for (int i = 0; i < 80; i++)
            send_sample(1'($urandom_range(0, 1)), random_sample());
        idling_on = 1'b1;
    endtask

    // Sender pauses until everything is back, then sends a burst again.
    task automatic test_pause_and_resume();
        write_select(FN_SHIFTED);
        for (int i = 0; i < 20; i++)
            send_sample(1'($urandom_range(0, 1)), random_sample());
        drain_results();
        for (int i = 0; i < 20; i++)
            send_sample(1'($urandom_range(0, 1)), random_sample());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        action         = 1'b0;
        sample         = '0;
        select_copy    = FN_IDENTITY;
        mismatch_count = 0;
        cycle_count    = 0;
        idling_on      = 1'b0;
        hold_cycles    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(130);
        test_backpressure();
        test_pause_and_resume();

        drain_results();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (expected_values.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected %0d, actual none",
                     $time, expected_values.size(), expected_values[0]);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("activation_function_unit_top verification clean");
        else
            $display("activation_function_unit_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/afu_pkg.sv
rtl/core/afu_exp.sv
rtl/core/afu_div.sv
rtl/core/activation_function_unit_top.sv
rtl/core/afu_checker.sv
test/activation_function_unit_top_tb.sv
